/* design/wsfm_pkg.sv */
package wsfm_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [15:0] ADDR_WAVE_LO = 16'h4040;
  localparam logic [15:0] ADDR_WAVE_HI = 16'h407F;
  localparam logic [15:0] ADDR_VOL_ENV = 16'h4080;
  localparam logic [15:0] ADDR_FREQ_LO = 16'h4082;
  localparam logic [15:0] ADDR_FREQ_HI = 16'h4083;
  localparam logic [15:0] ADDR_GAIN_ENV = 16'h4084;
  localparam logic [15:0] ADDR_MOD_CNT = 16'h4085;
  localparam logic [15:0] ADDR_MOD_FLO = 16'h4086;
  localparam logic [15:0] ADDR_MOD_FHI = 16'h4087;
  localparam logic [15:0] ADDR_MOD_TAB = 16'h4088;
  localparam logic [15:0] ADDR_MASTER = 16'h4089;
  localparam logic [15:0] ADDR_ENV_RATE = 16'h408A;

  localparam logic [11:0] FREQ_MAX = 12'hFFF;

  // Steps of the modulation counter for each table code.
  function automatic logic signed [3:0] mod_step_of(input logic [2:0] code);
    logic signed [3:0] d;
    begin
      unique case (code)
        3'd0: d = 4'sd0;
        3'd1: d = 4'sd1;
        3'd2: d = 4'sd2;
        3'd3: d = 4'sd4;
        3'd4: d = 4'sd0;
        3'd5: d = -4'sd4;
        3'd6: d = -4'sd3;
        default: d = -4'sd1;
      endcase
      return d;
    end
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the incoming word
    logic step1;    // tick: envelopes, modulator, mod-table read issue
    logic step2;    // tick: counter update, first multiply
    logic step3;    // tick: second multiply
    logic step4;    // tick: phase, wave read issue
    logic finish;   // form the result
  } wsfm_cmd_t;

  typedef struct packed {
    logic is_tick;
  } wsfm_stat_t;

endpackage

/* design/wsfm_ram.sv */
module wsfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/wsfm_ctrl.sv */
module wsfm_ctrl import wsfm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  wsfm_stat_t stat,
  output wsfm_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_T1   = 7'b0000010,
    S_T2   = 7'b0000100,
    S_T3   = 7'b0001000,
    S_T4   = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_T1;
        end
      end
      S_T1: begin
        if (stat.is_tick) begin
          cmd.step1 = 1'b1;
          state_nxt = S_T2;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_T2: begin
        cmd.step2 = 1'b1;
        state_nxt = S_T3;
      end
      S_T3: begin
        cmd.step3 = 1'b1;
        state_nxt = S_T4;
      end
      S_T4: begin
        cmd.step4 = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/wsfm_dp.sv */
module wsfm_dp import wsfm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] in_tdata,
  input  wsfm_cmd_t   cmd,
  output wsfm_stat_t  stat,
  output logic [23:0] out_tdata
);

  logic [1:0]  c_r;
  logic [15:0] a_r;
  logic [7:0]  d_r;

  logic [21:0] main_phase_r, mod_phase_r;
  logic [6:0]  mod_counter_r;
  logic [11:0] pitch_r, mod_pitch_r;
  logic [5:0]  vol_r, gain_r, vol_spd_r, gain_spd_r;
  logic [10:0] mdiv_r;
  logic [5:0]  vdiv_r, gdiv_r;
  logic [7:0]  env_rate_r;
  logic        vol_dis_r, vol_grow_r, gain_dis_r, gain_grow_r;
  logic        halt_r, env_halt_r, mod_dis_r, wav_wr_r;
  logic [1:0]  atten_r;
  logic        mod_moved_r;
  logic signed [19:0] t1_r;
  logic signed [16:0] t2_r;
  logic [7:0]  rdata_r;
  logic [10:0] level_r;
  logic [5:0]  wave_q, rd_q;
  logic [2:0]  mod_q, mod_code;
  logic [63:0] wave_vld_r, mod_vld_r;
  logic        wave_vq_r, mod_vq_r;

  logic is_wr, in_wave;
  assign is_wr   = (c_r == CMD_WRITE);
  assign in_wave = (a_r >= ADDR_WAVE_LO) && (a_r <= ADDR_WAVE_HI);
  assign stat.is_tick = (c_r == CMD_TICK);

  // Wave table: written by bus, read either by bus or the phase.
  logic        wave_we;
  logic [5:0]  wave_ra;
  logic [21:0] phase_next;
  assign wave_we = cmd.load ? 1'b0 : (is_wr && in_wave && wav_wr_r && stat.is_tick == 1'b0
                   && cmd.step1 == 1'b0 && cmd.finish);
  assign wave_ra = cmd.step4 ? phase_next[21:16] : a_r[5:0];

  wsfm_ram #(.WIDTH(6), .DEPTH(64)) u_wave (
    .clk(clk), .we(wave_we), .waddr(a_r[5:0]), .wdata(d_r[5:0]),
    .raddr(wave_ra), .rdata(wave_q)
  );
  // Entries never written since reset read as zero.
  assign rd_q = wave_vq_r ? wave_q : 6'd0;

  // Modulation table.
  logic       mod_we;
  logic [21:0] mod_ph_adv;
  assign mod_ph_adv = mod_phase_r + {10'd0, mod_pitch_r};
  assign mod_we = cmd.finish && is_wr && (a_r == ADDR_MOD_TAB) && mod_dis_r;
  wsfm_ram #(.WIDTH(3), .DEPTH(64)) u_mod (
    .clk(clk), .we(mod_we), .waddr(mod_phase_r[21:16]), .wdata(d_r[2:0]),
    .raddr(mod_ph_adv[21:16]), .rdata(mod_q)
  );
  assign mod_code = mod_vq_r ? mod_q : 3'd0;

  // Frequency modulation arithmetic.
  logic signed [6:0]  cnt_s;
  logic signed [19:0] t_rnd;
  logic signed [15:0] t_sh;
  logic signed [22:0] prod2;
  logic signed [16:0] t_sh2;
  logic signed [17:0] fsum;
  logic [11:0]        freq;
  assign cnt_s = mod_counter_r;
  assign t_rnd = (t1_r > 0 && t1_r[3:0] != 4'd0) ? t1_r + 20'sd16 : t1_r;
  assign t_sh  = 16'(t_rnd >>> 4);
  assign prod2 = 23'(t_sh) * $signed({17'd0, gain_r});
  assign t_sh2 = 17'(prod2 >>> 6);
  always_comb begin
    fsum = $signed({6'b000000, pitch_r}) + 18'(t2_r);
    if (mod_dis_r || cnt_s == 7'sd0) begin
      freq = pitch_r;
    end else if (fsum < 0) begin
      freq = 12'd0;
    end else if (fsum > $signed({6'b000000, FREQ_MAX})) begin
      freq = FREQ_MAX;
    end else begin
      freq = fsum[11:0];
    end
  end
  assign phase_next = main_phase_r + {10'd0, freq};

  logic signed [7:0] cnt_new;
  assign cnt_new = 8'(cnt_s) + 8'(mod_step_of(mod_code));

  logic [5:0] vol_cap;
  assign vol_cap = (vol_r < 6'd32) ? vol_r : 6'd32;

  logic [11:0] period;
  logic [11:0] md_inc;
  logic [5:0]  vd_inc, gd_inc;
  assign period = ({4'd0, env_rate_r} + 12'd1) << 3;
  assign md_inc = {1'b0, mdiv_r} + 12'd1;
  assign vd_inc = vdiv_r + 6'd1;
  assign gd_inc = gdiv_r + 6'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_phase_r <= '0; mod_phase_r <= '0; mod_counter_r <= '0;
      pitch_r <= '0; mod_pitch_r <= '0; vol_r <= '0; gain_r <= '0;
      vol_spd_r <= '0; gain_spd_r <= '0; mdiv_r <= '0; vdiv_r <= '0; gdiv_r <= '0;
      env_rate_r <= '0; vol_dis_r <= 1'b0; vol_grow_r <= 1'b0; gain_dis_r <= 1'b0;
      gain_grow_r <= 1'b0; halt_r <= 1'b0; env_halt_r <= 1'b0; mod_dis_r <= 1'b0;
      wav_wr_r <= 1'b0; atten_r <= '0; mod_moved_r <= 1'b0;
      rdata_r <= '0; level_r <= '0;
      wave_vld_r <= '0; mod_vld_r <= '0; wave_vq_r <= 1'b0; mod_vq_r <= 1'b0;
    end else begin
      if (wave_we) wave_vld_r[a_r[5:0]] <= 1'b1;
      if (mod_we) mod_vld_r[mod_phase_r[21:16]] <= 1'b1;
      wave_vq_r <= wave_vld_r[wave_ra];
      mod_vq_r  <= mod_vld_r[mod_ph_adv[21:16]];
      if (cmd.load) begin
        c_r <= in_tdata[1:0];
        a_r <= in_tdata[17:2];
        d_r <= in_tdata[25:18];
      end
      if (cmd.step1) begin
        if (!halt_r && !env_halt_r) begin
          if (md_inc >= period) begin
            mdiv_r <= '0;
            if (!vol_dis_r) begin
              if (vd_inc >= vol_spd_r) begin
                vdiv_r <= '0;
                if (vol_grow_r) begin
                  if (vol_r < 6'd32) vol_r <= vol_r + 6'd1;
                end else if (vol_r != 6'd0) begin
                  vol_r <= vol_r - 6'd1;
                end
              end else begin
                vdiv_r <= vd_inc;
              end
            end
            if (!gain_dis_r) begin
              if (gd_inc >= gain_spd_r) begin
                gdiv_r <= '0;
                if (gain_grow_r) begin
                  if (gain_r < 6'd63) gain_r <= gain_r + 6'd1;
                end else if (gain_r != 6'd0) begin
                  gain_r <= gain_r - 6'd1;
                end
              end else begin
                gdiv_r <= gd_inc;
              end
            end
          end else begin
            mdiv_r <= md_inc[10:0];
          end
        end
        mod_moved_r <= 1'b0;
        if (!halt_r && !mod_dis_r && mod_pitch_r != 12'd0) begin
          mod_phase_r <= mod_ph_adv;
          mod_moved_r <= (mod_ph_adv[21:16] != mod_phase_r[21:16]);
        end
      end
      if (cmd.step2) begin
        if (mod_moved_r) begin
          if (mod_code == 3'd4) begin
            mod_counter_r <= '0;
            t1_r <= '0;
          end else begin
            if (cnt_new > 8'sd63) mod_counter_r <= 7'd63;
            else if (cnt_new < -8'sd64) mod_counter_r <= 7'h40;
            else mod_counter_r <= cnt_new[6:0];
            t1_r <= 20'((cnt_new > 8'sd63) ? 8'sd63 : (cnt_new < -8'sd64) ? -8'sd64 : cnt_new)
                    * $signed({8'd0, pitch_r});
          end
        end else begin
          t1_r <= 20'(cnt_s) * $signed({8'd0, pitch_r});
        end
      end
      if (cmd.step3) begin
        t2_r <= t_sh2;
      end
      if (cmd.step4) begin
        if (!wav_wr_r && !halt_r) main_phase_r <= phase_next;
      end
      if (cmd.finish) begin
        rdata_r <= '0;
        level_r <= '0;
        if (c_r == CMD_READ && in_wave) rdata_r <= {2'b00, rd_q};
        if (stat.is_tick && !wav_wr_r && !halt_r) level_r <= 11'(rd_q * vol_cap);
        if (is_wr) begin
          unique case (a_r)
            ADDR_VOL_ENV: begin
              vol_dis_r <= d_r[7]; vol_grow_r <= d_r[6]; vol_spd_r <= d_r[5:0];
              if (d_r[7]) vol_r <= d_r[5:0];
            end
            ADDR_FREQ_LO: pitch_r[7:0] <= d_r;
            ADDR_FREQ_HI: begin
              pitch_r[11:8] <= d_r[3:0]; halt_r <= d_r[7]; env_halt_r <= d_r[6];
              if (d_r[7]) mdiv_r <= '0;
            end
            ADDR_GAIN_ENV: begin
              gain_dis_r <= d_r[7]; gain_grow_r <= d_r[6]; gain_spd_r <= d_r[5:0];
              if (d_r[7]) gain_r <= d_r[5:0];
            end
            ADDR_MOD_CNT: mod_counter_r <= d_r[6:0];
            ADDR_MOD_FLO: mod_pitch_r[7:0] <= d_r;
            ADDR_MOD_FHI: begin
              mod_pitch_r[11:8] <= d_r[3:0]; mod_dis_r <= d_r[7];
              if (d_r[7]) mod_phase_r <= '0;
            end
            ADDR_MOD_TAB: begin
              if (mod_dis_r) mod_phase_r <= mod_phase_r + 22'h10000;
            end
            ADDR_MASTER: begin
              wav_wr_r <= d_r[7]; atten_r <= d_r[1:0];
            end
            ADDR_ENV_RATE: begin
              env_rate_r <= d_r; mdiv_r <= '0;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // rdata, audio_level, master_atten from the lowest bit up.
  assign out_tdata = {3'd0, atten_r, level_r, rdata_r};

endmodule

/* design/wavetable_synth_with_fm_top.sv */
// Wavetable sound channel with frequency modulation.
// The input stream carries one word per bus operation: a register write,
// a wave-table read or one audio clock tick, selected by the cmd field.
// Every input word yields exactly one output word holding the read data,
// the audio level (wave sample times volume capped at 32, zero when the
// channel is halted or in wave-write mode) and the master attenuation index.
// A tick passes from acceptance to the earliest hand-over of its result
// through the envelope and modulator step with a modulation-table read, the
// counter update and first multiply, the gain multiply, the phase update
// with a wave-table read, and the result register. Writes and reads skip
// the tick steps; the dependent multiply chain makes the tick the longer path.
// One word is in flight at a time; the next can be accepted in the cycle
// after the result is taken. The result waits in its output register while
// the receiver stalls, and no new word is taken until it has been delivered.
// After synchronous reset all registers but the captured word and the
// multiply products are cleared, and both tables read as zero until an
// entry is written, tracked by a valid bit per entry.
module wavetable_synth_with_fm_top import wsfm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // cmd[1:0], addr[17:2], wdata[25:18]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // rdata[7:0], audio_level[18:8], master_atten[20:19]
);

  wsfm_cmd_t  cmd;
  wsfm_stat_t stat;

  wsfm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .stat(stat), .cmd(cmd)
  );

  wsfm_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_tdata(in_tdata), .cmd(cmd),
    .stat(stat), .out_tdata(out_tdata)
  );

  // No word is taken while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken with result pending");

  // A result stays offered until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");

  // An accepted word starts the controller, which closes the input until
  // its result has been taken.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("controller did not start");

endmodule

/* tb/wsfm_scoreboard.sv */
`timescale 1ns / 1ps

// Watches both streams, keeps its own model of the sound channel and checks
// every output word against the oldest predicted word.
module wsfm_scoreboard import wsfm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [1:0]  atten;
    logic [10:0] level;
    logic [7:0]  rdata;
  } chan_word_t;

  chan_word_t predicted_q[$];

  logic [5:0]  wave_mem [64];
  logic [2:0]  mod_mem [64];
  logic [21:0] main_phase, mod_phase;
  logic [6:0]  mod_cnt;
  logic [11:0] pitch, mod_pitch;
  logic [5:0]  vol_lvl, gain_lvl, vol_spd, gain_spd, vol_div, gain_div;
  logic [10:0] env_master;
  logic [7:0]  env_rate;
  logic        vol_dis, vol_grow, gain_dis, gain_grow;
  logic        halt, env_halt, mod_dis, wave_wr;
  logic [1:0]  atten;

  const int mod_steps [8] = '{0, 1, 2, 4, 0, -4, -3, -1};

  int mismatches = 0;
  assign fail_count    = mismatches;
  assign pending_count = predicted_q.size();

  task automatic clear_channel();
    for (int i = 0; i < 64; i++) begin
      wave_mem[i] = '0;
      mod_mem[i]  = '0;
    end
    {main_phase, mod_phase, mod_cnt, pitch, mod_pitch} = '0;
    {vol_lvl, gain_lvl, vol_spd, gain_spd, vol_div, gain_div} = '0;
    {env_master, env_rate, vol_dis, vol_grow, gain_dis, gain_grow} = '0;
    {halt, env_halt, mod_dis, wave_wr, atten} = '0;
  endtask

  function automatic void envelope_clock(inout logic [5:0] div, input logic [5:0] spd,
                                         input logic grow, inout logic [5:0] lvl,
                                         input int cap);
    int d;
    d = int'(div) + 1;
    if (d >= int'(spd)) begin
      d = 0;
      if (grow) begin
        if (int'(lvl) < cap) lvl = lvl + 1'b1;
      end else if (lvl != 0) begin
        lvl = lvl - 1'b1;
      end
    end
    div = d[5:0];
  endfunction

  task automatic bus_write(input logic [15:0] a, input logic [7:0] v);
    if (a >= ADDR_WAVE_LO && a <= ADDR_WAVE_HI) begin
      if (wave_wr) wave_mem[a[5:0]] = v[5:0];
    end else begin
      case (a)
        ADDR_VOL_ENV: begin
          vol_dis  = v[7];
          vol_grow = v[6];
          vol_spd  = v[5:0];
          if (v[7]) vol_lvl = v[5:0];
        end
        ADDR_FREQ_LO: pitch[7:0] = v;
        ADDR_FREQ_HI: begin
          pitch[11:8] = v[3:0];
          halt     = v[7];
          env_halt = v[6];
          if (v[7]) env_master = '0;
        end
        ADDR_GAIN_ENV: begin
          gain_dis  = v[7];
          gain_grow = v[6];
          gain_spd  = v[5:0];
          if (v[7]) gain_lvl = v[5:0];
        end
        ADDR_MOD_CNT: mod_cnt = v[6:0];
        ADDR_MOD_FLO: mod_pitch[7:0] = v;
        ADDR_MOD_FHI: begin
          mod_pitch[11:8] = v[3:0];
          mod_dis = v[7];
          if (v[7]) mod_phase = '0;
        end
        ADDR_MOD_TAB: begin
          if (mod_dis) begin
            mod_mem[mod_phase[21:16]] = v[2:0];
            mod_phase = mod_phase + 22'h10000;
          end
        end
        ADDR_MASTER: begin
          wave_wr = v[7];
          atten   = v[1:0];
        end
        ADDR_ENV_RATE: begin
          env_rate   = v;
          env_master = '0;
        end
        default: ;
      endcase
    end
  endtask

  // One audio clock: envelopes, modulator, then the main oscillator.
  function automatic logic [10:0] audio_tick();
    int md, period, c, t, f;
    logic [5:0] old_pos;
    if (!halt && !env_halt) begin
      md = int'(env_master) + 1;
      period = (int'(env_rate) + 1) * 8;
      if (md >= period) begin
        md = 0;
        if (!vol_dis) envelope_clock(vol_div, vol_spd, vol_grow, vol_lvl, 32);
        if (!gain_dis) envelope_clock(gain_div, gain_spd, gain_grow, gain_lvl, 63);
      end
      env_master = md[10:0];
    end
    if (!halt && !mod_dis && mod_pitch != 0) begin
      old_pos = mod_phase[21:16];
      mod_phase = mod_phase + 22'(mod_pitch);
      if (mod_phase[21:16] != old_pos) begin
        if (mod_mem[mod_phase[21:16]] == 3'd4) begin
          mod_cnt = '0;
        end else begin
          c = int'($signed(mod_cnt)) + mod_steps[mod_mem[mod_phase[21:16]]];
          if (c > 63) c = 63;
          if (c < -64) c = -64;
          mod_cnt = c[6:0];
        end
      end
    end
    if (wave_wr || halt) return '0;
    f = int'(pitch);
    c = int'($signed(mod_cnt));
    if (!mod_dis && c != 0) begin
      t = c * f;
      // Positive products with a fraction round up before the shift.
      if (t > 0 && (t % 16) != 0) t = t + 16;
      t = t >>> 4;
      t = (t * int'(gain_lvl)) >>> 6;
      f = f + t;
      if (f < 0) f = 0;
      if (f > int'(FREQ_MAX)) f = int'(FREQ_MAX);
    end
    main_phase = main_phase + 22'(f);
    return 11'(wave_mem[main_phase[21:16]] * ((vol_lvl < 32) ? vol_lvl : 6'd32));
  endfunction

  always @(posedge clk) begin
    chan_word_t w, got;
    if (!rst_n) begin
      clear_channel();
      predicted_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[20:0];
        if (predicted_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: output word %h with nothing predicted", $realtime, out_tdata);
        end else begin
          w = predicted_q.pop_front();
          if (got !== w || out_tdata[23:21] !== 3'b0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: rdata %h/%h level %0d/%0d atten %0d/%0d (expected/actual)",
                       $realtime, w.rdata, got.rdata, w.level, got.level,
                       w.atten, got.atten);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        w = '0;
        case (in_tdata[1:0])
          CMD_WRITE: bus_write(in_tdata[17:2], in_tdata[25:18]);
          CMD_READ: begin
            if (in_tdata[17:2] >= ADDR_WAVE_LO && in_tdata[17:2] <= ADDR_WAVE_HI)
              w.rdata = {2'b0, wave_mem[in_tdata[7:2]]};
          end
          CMD_TICK: w.level = audio_tick();
          default: ;
        endcase
        w.atten = atten;
        predicted_q.push_back(w);
      end
    end
  end

endmodule

/* tb/wavetable_synth_with_fm_top_tb.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the wavetable sound channel. The checker beside
// the block predicts and compares; this module feeds words, drives ready and waits.
module wavetable_synth_with_fm_top_tb;
  import wsfm_pkg::*;

  // The fourth command value is not a bus operation; the block treats it as
  // a no-op word that still reports the attenuation.
  localparam logic [1:0] CMD_IDLE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  int fail_count, pending_count;
  int words_sent = 0;
  int burst_left = 0;
  int hold_cycles = 0;
  bit valid_low = 1'b1;
  bit stall_done = 1'b0;
  bit drain_done = 1'b0;

  wavetable_synth_with_fm_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  wsfm_scoreboard u_scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver switches between always ready, half ready and mostly
  // stalled, and honours a long hold-off when the stimulus asks for one.
  initial begin
    int rx_mode, mode_left;
    rx_mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offers one word and waits for its handshake. Between bursts the valid
  // drops; bursts can be long enough to leave no gaps.
  task automatic send_word(input logic [1:0] cmd, input logic [15:0] addr,
                           input logic [7:0] wdata);
    in_tdata  <= {6'b0, wdata, addr, cmd};
    in_tvalid <= 1'b1;
    valid_low = 1'b0;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      valid_low = 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 60);
    end else begin
      burst_left--;
    end
  endtask

  // Stops offering words until every predicted word has come out.
  task automatic drain_channel();
    if (!valid_low) in_tvalid <= 1'b0;
    valid_low = 1'b1;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic load_wave_table(input int first, input int count, input logic [1:0] att);
    send_word(CMD_WRITE, ADDR_MASTER, {1'b1, 5'($urandom), att});
    for (int i = 0; i < count; i++)
      send_word(CMD_WRITE, ADDR_WAVE_LO + 16'((first + i) % 64), 8'($urandom));
    send_word(CMD_WRITE, ADDR_MASTER, {1'b0, 5'($urandom), att});
  endtask

  // Disabling the modulator rewinds its phase, so the table fills from entry 0.
  task automatic load_mod_table(input int count);
    send_word(CMD_WRITE, ADDR_MOD_FHI, {1'b1, 3'($urandom), 4'($urandom)});
    for (int i = 0; i < count; i++)
      send_word(CMD_WRITE, ADDR_MOD_TAB, 8'($urandom));
    send_word(CMD_WRITE, ADDR_MOD_FHI, {1'b0, 3'($urandom), 4'($urandom)});
  endtask

  // A random word, weighted towards ticks and sound-register writes.
  task automatic random_word();
    int pick, reg_ofs;
    logic [7:0] v;
    pick = $urandom_range(0, 99);
    v = 8'($urandom);
    if (pick < 55) begin
      send_word(CMD_TICK, 16'($urandom), v);
    end else if (pick < 80) begin
      reg_ofs = $urandom_range(0, 10);
      // The wave halt and wave-write mode are kept rare so that most ticks play.
      case (ADDR_VOL_ENV + 16'(reg_ofs))
        ADDR_FREQ_HI, ADDR_MASTER: v[7] = ($urandom_range(0, 7) == 0);
        ADDR_MOD_FHI: v[7] = ($urandom_range(0, 3) == 0);
        ADDR_ENV_RATE: if ($urandom_range(0, 3) != 0) v = 8'($urandom_range(0, 3));
        default: ;
      endcase
      send_word(CMD_WRITE, ADDR_VOL_ENV + 16'(reg_ofs), v);
    end else if (pick < 85) begin
      send_word(CMD_READ, ADDR_WAVE_LO + 16'($urandom_range(0, 63)), v);
    end else if (pick < 88) begin
      send_word(CMD_WRITE, ADDR_WAVE_LO + 16'($urandom_range(0, 63)), v);
    end else if (pick < 91) begin
      load_mod_table($urandom_range(1, 6));
    end else if (pick < 94) begin
      load_wave_table($urandom_range(0, 63), $urandom_range(2, 8), 2'($urandom));
    end else if (pick < 98) begin
      send_word(2'($urandom_range(0, 1)), 16'($urandom), v);
    end else begin
      send_word(CMD_IDLE, 16'($urandom), v);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both tables are filled first so that no entry is read before it is written.
    load_wave_table(0, 64, 2'd0);
    load_mod_table(64);

    // Register extremes, muted ticks and ignored addresses.
    send_word(CMD_WRITE, ADDR_WAVE_LO, 8'hFF);          // ignored outside wave-write mode
    send_word(CMD_READ, ADDR_WAVE_LO, 8'h00);
    send_word(CMD_READ, ADDR_WAVE_HI, 8'hFF);
    send_word(CMD_WRITE, ADDR_VOL_ENV, 8'hBF);          // volume 63, capped at 32
    send_word(CMD_WRITE, ADDR_GAIN_ENV, 8'hBF);
    send_word(CMD_WRITE, ADDR_FREQ_LO, 8'hFF);
    send_word(CMD_WRITE, ADDR_FREQ_HI, 8'h0F);
    send_word(CMD_WRITE, ADDR_MOD_CNT, 8'h40);          // most negative counter
    send_word(CMD_WRITE, ADDR_MOD_FLO, 8'hFF);
    send_word(CMD_TICK, 16'h0000, 8'h00);
    send_word(CMD_WRITE, ADDR_MOD_CNT, 8'h3F);          // most positive counter
    send_word(CMD_TICK, 16'hFFFF, 8'hFF);
    send_word(CMD_WRITE, ADDR_ENV_RATE, 8'h00);
    send_word(CMD_WRITE, ADDR_VOL_ENV, 8'h40);          // growing volume, speed zero
    send_word(CMD_WRITE, ADDR_GAIN_ENV, 8'h00);         // shrinking gain, speed zero
    repeat (4) send_word(CMD_TICK, 16'h4080, 8'h00);
    send_word(CMD_WRITE, ADDR_FREQ_HI, 8'h8F);          // wave halt mutes the tick
    send_word(CMD_TICK, 16'h4083, 8'h00);
    send_word(CMD_WRITE, ADDR_FREQ_HI, 8'h4F);          // envelope halt only
    send_word(CMD_WRITE, ADDR_MASTER, 8'h83);           // wave-write mode mutes too
    send_word(CMD_TICK, 16'h4089, 8'h00);
    send_word(CMD_WRITE, ADDR_MASTER, 8'h02);
    send_word(CMD_WRITE, 16'h4081, 8'hFF);
    send_word(CMD_READ, 16'h4081, 8'h00);
    send_word(CMD_WRITE, 16'h408B, 8'hAA);
    send_word(CMD_IDLE, 16'h5555, 8'h55);
    send_word(CMD_WRITE, ADDR_FREQ_HI, 8'h03);

    while (words_sent < 900) begin
      random_word();
      if (!stall_done && words_sent >= 350 && hold_cycles == 0) begin
        // The receiver stalls for a long stretch while words keep coming.
        stall_done = 1'b1;
        hold_cycles = 400;
        repeat (5) random_word();
      end
      if (!drain_done && words_sent >= 600) begin
        drain_done = 1'b1;
        drain_channel();
      end
    end

    drain_channel();
    repeat (20) @(posedge clk);
    $display("Covered %0d words: table loads, register extremes, muted and modulated ticks,",
             words_sent);
    $display("ignored addresses, a long output stall and a full drain.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS wavetable_synth_with_fm_top");
    end else begin
      $display("FAIL wavetable_synth_with_fm_top");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL wavetable_synth_with_fm_top");
    $finish;
  end

endmodule

/* filelist.f */
design/wsfm_pkg.sv
design/wsfm_ram.sv
design/wsfm_ctrl.sv
design/wsfm_dp.sv
design/wavetable_synth_with_fm_top.sv
tb/wsfm_scoreboard.sv
tb/wavetable_synth_with_fm_top_tb.sv
